// ----- rtl/rfki_pkg.sv -----
// shared types and constants for the rigid frame keyframe interpolator
// no dependencies; used by rfki_div, rfki_sqrt and the top level
package rfki_pkg;

  localparam int MAX_STEPS = 63;
  localparam int STEP_W    = 6;
  localparam int SLOT_W    = 8;
  localparam int POS_W     = 32;
  localparam int ROT_W     = 16;
  localparam int BLEND_W   = 23;
  localparam int SUMSQ_W   = 46;
  localparam int DIV_NW    = 46;
  localparam int DIV_DW    = 32;
  localparam int SQRT_XW   = 64;
  localparam int SQRT_RW   = 32;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_STEP_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_SLOT = 2'd1;

  localparam logic [ROT_W-2:0] ROT_ONE = 15'd16384;

  typedef struct packed {
    logic              start;
    logic [DIV_NW-1:0] num;
    logic [DIV_DW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_NW-1:0] quo;
  } div_rsp_t;

  typedef struct packed {
    logic               start;
    logic [SQRT_XW-1:0] x;
  } sqrt_req_t;

  typedef struct packed {
    logic               done;
    logic [SQRT_RW-1:0] root;
  } sqrt_rsp_t;

endpackage

// ----- rtl/rigid_frame_keyframe_interpolator.sv -----
// Keyframe interpolator for rigid frames. An item with action 0 holds a start
// frame; an item with action 1 gives the end frame and produces step_count+1
// frames (two when step_count is 0), positions linear in Q16.16 and rotations
// as a renormalised Q1.14 blend. Each frame forms the blend and its sum of
// squares, takes a 32-step square root, and runs seven 46-step divisions
// (three positions, four rotation components) one after another on a single
// shared divider. A zero-length blend skips the four rotation divisions.
// in_ready is low while frames are being produced.
// top level; depends on rfki_pkg, rfki_div and rfki_sqrt
module rigid_frame_keyframe_interpolator (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_action,
  input  logic signed [rfki_pkg::POS_W-1:0]    in_pos_x,
  input  logic signed [rfki_pkg::POS_W-1:0]    in_pos_y,
  input  logic signed [rfki_pkg::POS_W-1:0]    in_pos_z,
  input  logic signed [rfki_pkg::ROT_W-1:0]    in_rot_w,
  input  logic signed [rfki_pkg::ROT_W-1:0]    in_rot_x,
  input  logic signed [rfki_pkg::ROT_W-1:0]    in_rot_y,
  input  logic signed [rfki_pkg::ROT_W-1:0]    in_rot_z,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [rfki_pkg::SLOT_W:0]            out_slot,
  output logic signed [rfki_pkg::POS_W-1:0]    out_pos_x,
  output logic signed [rfki_pkg::POS_W-1:0]    out_pos_y,
  output logic signed [rfki_pkg::POS_W-1:0]    out_pos_z,
  output logic signed [rfki_pkg::ROT_W-1:0]    out_rot_w,
  output logic signed [rfki_pkg::ROT_W-1:0]    out_rot_x,
  output logic signed [rfki_pkg::ROT_W-1:0]    out_rot_y,
  output logic signed [rfki_pkg::ROT_W-1:0]    out_rot_z,
  output logic                                 out_last,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [rfki_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [7:0]                           cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE, S_BCALC, S_SQ, S_SQRT, S_SQRT_W, S_DIV, S_DIV_W, S_OUT
  } state_t;

  state_t state_r;

  logic [rfki_pkg::STEP_W-1:0]          step_count_r;
  logic [rfki_pkg::SLOT_W-1:0]          start_slot_r;
  logic signed [rfki_pkg::POS_W-1:0]    held_pos_r [3];
  logic signed [rfki_pkg::ROT_W-1:0]    held_rot_r [4];
  logic signed [rfki_pkg::POS_W-1:0]    end_pos_r  [3];
  logic signed [rfki_pkg::ROT_W-1:0]    end_rot_r  [4];
  logic signed [rfki_pkg::BLEND_W-1:0]  b_r        [4];
  logic [rfki_pkg::STEP_W-1:0]          n_r;
  logic [rfki_pkg::STEP_W-1:0]          i_r;
  logic [2:0]                           k_r;
  logic [rfki_pkg::SUMSQ_W-3:0]         sq_r;
  logic [rfki_pkg::SUMSQ_W-1:0]         s_r;
  logic [rfki_pkg::SQRT_RW-1:0]         norm_r;
  logic                                 out_valid_r;

  rfki_pkg::div_req_t   div_req;
  rfki_pkg::div_rsp_t   div_rsp;
  rfki_pkg::sqrt_req_t  sqrt_req;
  rfki_pkg::sqrt_rsp_t  sqrt_rsp;

  logic [rfki_pkg::STEP_W-1:0]          n_eff;
  logic signed [rfki_pkg::BLEND_W-1:0]  b_nxt [4];
  logic signed [rfki_pkg::BLEND_W-1:0]  b_sel;
  logic signed [2*rfki_pkg::BLEND_W-1:0] b_sq;
  logic signed [rfki_pkg::POS_W:0]      d_sel;
  logic signed [rfki_pkg::POS_W-1:0]    h_sel;
  logic signed [rfki_pkg::POS_W+7:0]    p_val;
  logic [rfki_pkg::POS_W+7:0]           p_mag;
  logic [rfki_pkg::BLEND_W-1:0]         b_mag;
  logic                                 neg_sel;
  logic                                 is_rot;
  logic                                 s_zero;
  logic [rfki_pkg::POS_W+1:0]           pos_res;
  logic [rfki_pkg::ROT_W-2:0]           rot_mag;
  logic [rfki_pkg::ROT_W-1:0]           rot_res;

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign is_rot    = (k_r >= 3'd3);
  assign s_zero    = (s_r == '0);

  always_comb begin
    n_eff = step_count_r;
    if (step_count_r == '0) n_eff = 6'd1;
    if (step_count_r > 6'(rfki_pkg::MAX_STEPS)) n_eff = 6'(rfki_pkg::MAX_STEPS);
  end

  // blend without the common 1/n factor
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      b_nxt[k] = rfki_pkg::BLEND_W'(held_rot_r[k] * $signed({1'b0, n_r - i_r}))
               + rfki_pkg::BLEND_W'(end_rot_r[k] * $signed({1'b0, i_r}));
    end
  end

  always_comb begin
    b_sel = b_r[0];
    case (k_r)
      3'd1, 3'd4: b_sel = b_r[1];
      3'd2, 3'd5: b_sel = b_r[2];
      3'd3:       b_sel = b_r[0];
      3'd6:       b_sel = b_r[3];
      default:    b_sel = b_r[0];
    endcase
    // the sum of squares walks the components in order
    if (state_r == S_SQ) b_sel = b_r[k_r[1:0]];
    b_sq = b_sel * b_sel;
  end

  always_comb begin
    case (k_r)
      3'd1:    begin d_sel = end_pos_r[1] - held_pos_r[1]; h_sel = held_pos_r[1]; end
      3'd2:    begin d_sel = end_pos_r[2] - held_pos_r[2]; h_sel = held_pos_r[2]; end
      default: begin d_sel = end_pos_r[0] - held_pos_r[0]; h_sel = held_pos_r[0]; end
    endcase
  end

  always_comb begin
    p_val   = d_sel * $signed({1'b0, i_r});
    p_mag   = p_val[rfki_pkg::POS_W+7] ? (~p_val + 1'b1) : p_val;
    b_mag   = b_sel[rfki_pkg::BLEND_W-1] ? (~b_sel + 1'b1) : b_sel;
    neg_sel = is_rot ? b_sel[rfki_pkg::BLEND_W-1] : p_val[rfki_pkg::POS_W+7];

    div_req.start = (state_r == S_DIV) && !(is_rot && s_zero);
    if (is_rot) begin
      div_req.num = 46'({b_mag[rfki_pkg::BLEND_W-2:0], 23'd0}) + 46'(norm_r >> 1);
      div_req.den = norm_r;
    end else begin
      div_req.num = 46'(p_mag) + 46'(n_r >> 1);
      div_req.den = 32'(n_r);
    end

    sqrt_req.start = (state_r == S_SQRT);
    sqrt_req.x     = {s_r, 18'd0};

    pos_res = {{2{h_sel[rfki_pkg::POS_W-1]}}, h_sel}
            + (neg_sel ? (~{1'b0, div_rsp.quo[rfki_pkg::POS_W:0]} + 1'b1)
                       : {1'b0, div_rsp.quo[rfki_pkg::POS_W:0]});

    if ((|div_rsp.quo[rfki_pkg::DIV_NW-1:rfki_pkg::ROT_W-1])
        || (div_rsp.quo[rfki_pkg::ROT_W-2:0] > rfki_pkg::ROT_ONE))
      rot_mag = rfki_pkg::ROT_ONE;
    else
      rot_mag = div_rsp.quo[rfki_pkg::ROT_W-2:0];
    rot_res = neg_sel ? (~{1'b0, rot_mag} + 1'b1) : {1'b0, rot_mag};
  end

  rfki_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  rfki_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (sqrt_req),
    .rsp   (sqrt_rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      step_count_r <= 6'd1;
      start_slot_r <= '0;
      k_r          <= '0;
      i_r          <= '0;
      n_r          <= 6'd1;
      for (int k = 0; k < 3; k++) held_pos_r[k] <= '0;
      for (int k = 0; k < 4; k++) held_rot_r[k] <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          rfki_pkg::REG_STEP_COUNT: step_count_r <= cfg_data[rfki_pkg::STEP_W-1:0];
          rfki_pkg::REG_START_SLOT: start_slot_r <= cfg_data;
          default: ;
        endcase
      end

      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            if (!in_action) begin
              held_pos_r[0] <= in_pos_x;
              held_pos_r[1] <= in_pos_y;
              held_pos_r[2] <= in_pos_z;
              held_rot_r[0] <= in_rot_w;
              held_rot_r[1] <= in_rot_x;
              held_rot_r[2] <= in_rot_y;
              held_rot_r[3] <= in_rot_z;
            end else begin
              end_pos_r[0] <= in_pos_x;
              end_pos_r[1] <= in_pos_y;
              end_pos_r[2] <= in_pos_z;
              end_rot_r[0] <= in_rot_w;
              end_rot_r[1] <= in_rot_x;
              end_rot_r[2] <= in_rot_y;
              end_rot_r[3] <= in_rot_z;
              n_r     <= n_eff;
              i_r     <= '0;
              state_r <= S_BCALC;
            end
          end
        end
        S_BCALC: begin
          for (int k = 0; k < 4; k++) b_r[k] <= b_nxt[k];
          s_r     <= '0;
          k_r     <= '0;
          state_r <= S_SQ;
        end
        S_SQ: begin
          // square of the current component, summed in the following cycle
          if (k_r < 3'd4) sq_r <= b_sq[rfki_pkg::SUMSQ_W-3:0];
          if (k_r != 3'd0) s_r <= s_r + rfki_pkg::SUMSQ_W'(sq_r);
          if (k_r == 3'd4) begin
            state_r <= S_SQRT;
          end else begin
            k_r <= k_r + 3'd1;
          end
        end
        S_SQRT: state_r <= S_SQRT_W;
        S_SQRT_W: begin
          if (sqrt_rsp.done) begin
            norm_r  <= sqrt_rsp.root;
            k_r     <= '0;
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          if (is_rot && s_zero) begin
            case (k_r)
              3'd3:    out_rot_w <= '0;
              3'd4:    out_rot_x <= '0;
              3'd5:    out_rot_y <= '0;
              default: out_rot_z <= '0;
            endcase
            if (k_r == 3'd6) begin
              out_valid_r <= 1'b1;
              state_r     <= S_OUT;
            end
            k_r <= k_r + 3'd1;
          end else begin
            state_r <= S_DIV_W;
          end
        end
        S_DIV_W: begin
          if (div_rsp.done) begin
            case (k_r)
              3'd0:    out_pos_x <= pos_res[rfki_pkg::POS_W-1:0];
              3'd1:    out_pos_y <= pos_res[rfki_pkg::POS_W-1:0];
              3'd2:    out_pos_z <= pos_res[rfki_pkg::POS_W-1:0];
              3'd3:    out_rot_w <= rot_res;
              3'd4:    out_rot_x <= rot_res;
              3'd5:    out_rot_y <= rot_res;
              default: out_rot_z <= rot_res;
            endcase
            k_r <= k_r + 3'd1;
            if (k_r == 3'd6) begin
              out_valid_r <= 1'b1;
              state_r     <= S_OUT;
            end else begin
              state_r <= S_DIV;
            end
          end
        end
        S_OUT: begin
          out_slot <= {1'b0, start_slot_r} + {3'd0, i_r};
          out_last <= (i_r == n_r);
          if (out_valid_r && out_ready) begin
            out_valid_r <= 1'b0;
            if (i_r == n_r) begin
              state_r <= S_IDLE;
            end else begin
              i_r     <= i_r + 6'd1;
              state_r <= S_BCALC;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase

      // slot and last ride with the frame as soon as it is shown
      if ((state_r == S_DIV_W && div_rsp.done && k_r == 3'd6)
          || (state_r == S_DIV && is_rot && s_zero && k_r == 3'd6)) begin
        out_slot <= {1'b0, start_slot_r} + {3'd0, i_r};
        out_last <= (i_r == n_r);
      end
    end
  end

endmodule

// ----- rtl/rfki_div.sv -----
// restoring divider, one quotient bit per cycle
// depends on rfki_pkg
module rfki_div (
  input  logic                clk,
  input  logic                rst_n,
  input  rfki_pkg::div_req_t  req,
  output rfki_pkg::div_rsp_t  rsp
);

  logic                          busy_r;
  logic                          done_r;
  logic [5:0]                    cnt_r;
  logic [rfki_pkg::DIV_NW-1:0]   num_r;
  logic [rfki_pkg::DIV_DW-1:0]   den_r;
  logic [rfki_pkg::DIV_DW-1:0]   rem_r;
  logic [rfki_pkg::DIV_DW:0]     rem_sh;
  logic                          ge;
  logic [rfki_pkg::DIV_DW:0]     rem_nxt;

  always_comb begin
    rem_sh  = {rem_r, num_r[rfki_pkg::DIV_NW-1]};
    ge      = rem_sh >= {1'b0, den_r};
    rem_nxt = ge ? (rem_sh - {1'b0, den_r}) : rem_sh;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'(rfki_pkg::DIV_NW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // quotient bits shift into the numerator register as it empties
  always_ff @(posedge clk) begin
    if (req.start) begin
      num_r <= req.num;
      den_r <= req.den;
      rem_r <= '0;
    end else if (busy_r) begin
      num_r <= {num_r[rfki_pkg::DIV_NW-2:0], ge};
      rem_r <= rem_nxt[rfki_pkg::DIV_DW-1:0];
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo  = num_r;

endmodule

// ----- rtl/rfki_sqrt.sv -----
// digit-by-digit integer square root, one root bit per cycle
// depends on rfki_pkg
module rfki_sqrt (
  input  logic                 clk,
  input  logic                 rst_n,
  input  rfki_pkg::sqrt_req_t  req,
  output rfki_pkg::sqrt_rsp_t  rsp
);

  logic                           busy_r;
  logic                           done_r;
  logic [4:0]                     cnt_r;
  logic [rfki_pkg::SQRT_XW-1:0]   x_r;
  logic [rfki_pkg::SQRT_RW+1:0]   rem_r;
  logic [rfki_pkg::SQRT_RW-1:0]   root_r;
  logic [rfki_pkg::SQRT_RW+3:0]   rem_sh;
  logic [rfki_pkg::SQRT_RW+3:0]   trial;
  logic                           ge;
  logic [rfki_pkg::SQRT_RW+3:0]   rem_nxt;

  always_comb begin
    rem_sh  = {rem_r, x_r[rfki_pkg::SQRT_XW-1 -: 2]};
    trial   = {2'b00, root_r, 2'b01};
    ge      = rem_sh >= trial;
    rem_nxt = ge ? (rem_sh - trial) : rem_sh;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'(rfki_pkg::SQRT_RW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      x_r    <= req.x;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      x_r    <= {x_r[rfki_pkg::SQRT_XW-3:0], 2'b00};
      rem_r  <= rem_nxt[rfki_pkg::SQRT_RW+1:0];
      root_r <= {root_r[rfki_pkg::SQRT_RW-2:0], ge};
    end
  end

  assign rsp.done = done_r;
  assign rsp.root = root_r;

endmodule
